/* rtl/core/l2cap_pkg.sv */
// shared types and constants for the l2cap signalling channel engine
// no dependencies
package l2cap_pkg;

  localparam int unsigned Channels = 8;
  localparam int unsigned IdxW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned CntW = $clog2(Channels + 1);

  localparam logic [15:0] MtuReset = 16'd672;
  localparam logic [15:0] LcidOffset = 16'd4;

  localparam logic [1:0] OP_RX = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_DISC = 2'd2;

  localparam logic [2:0] KIND_SIG = 3'd0;
  localparam logic [2:0] KIND_DATA = 3'd1;
  localparam logic [2:0] KIND_SDP = 3'd2;
  localparam logic [2:0] KIND_RFCOMM = 3'd3;
  localparam logic [2:0] KIND_NONE = 3'd4;
  localparam logic [2:0] KIND_ERR = 3'd5;

  localparam logic [2:0] ERR_OK = 3'd0;
  localparam logic [2:0] ERR_SIZE = 3'd1;
  localparam logic [2:0] ERR_CONT = 3'd2;
  localparam logic [2:0] ERR_CID = 3'd3;
  localparam logic [2:0] ERR_NOCH = 3'd4;
  localparam logic [2:0] ERR_NOTOPEN = 3'd5;
  localparam logic [2:0] ERR_FULL = 3'd6;

  localparam logic [7:0] CMD_CONN_REQ = 8'h02;
  localparam logic [7:0] CMD_CONN_RSP = 8'h03;
  localparam logic [7:0] CMD_CFG_REQ = 8'h04;
  localparam logic [7:0] CMD_CFG_RSP = 8'h05;
  localparam logic [7:0] CMD_DISC_REQ = 8'h06;
  localparam logic [7:0] CMD_DISC_RSP = 8'h07;
  localparam logic [7:0] CMD_INFO_REQ = 8'h0A;
  localparam logic [7:0] CMD_INFO_RSP = 8'h0B;

  localparam logic [1:0] PH_WCFG = 2'd0;
  localparam logic [1:0] PH_WRSP = 2'd1;
  localparam logic [1:0] PH_OPEN = 2'd2;

  localparam logic [15:0] CID_SIG = 16'd1;
  localparam logic [15:0] CID_DYN = 16'd64;
  localparam logic [15:0] PSM_SDP = 16'd1;
  localparam logic [15:0] PSM_RFCOMM = 16'd3;
  localparam logic [15:0] OPT_MTU_HDR = 16'h0201;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] buf_len;
    logic        continuation;
    logic [15:0] frame_len;
    logic [15:0] cid;
    logic [7:0]  cmd_code;
    logic [7:0]  cmd_id;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] psm;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [7:0]  ident;
    logic [15:0] out_cid;
    logic [15:0] out_len;
    logic [15:0] param0;
    logic [15:0] param1;
    logic [15:0] param2;
    logic [15:0] param3;
    logic [2:0]  error;
    logic        last;
  } result_t;

  // search kinds for the table scan
  localparam logic [1:0] SRCH_LCID = 2'd0;
  localparam logic [1:0] SRCH_PSM = 2'd1;
  localparam logic [1:0] SRCH_FREE = 2'd2;

  typedef struct packed {
    logic       load;      // capture input item
    logic       scan_start;
    logic [1:0] scan_kind;
    logic       decide;    // form result(s) and update entry
    logic       emit2;     // present second result
  } cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic two_results;
  } stat_t;

endpackage

/* rtl/core/l2cap_datapath.sv */
// datapath: item register, channel table, sequential scan and result forming
// depends on l2cap_pkg
module l2cap_datapath import l2cap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       item_i,
  input  logic [15:0] mtu_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output result_t     res_o
);

  item_t item_q;
  logic [Channels-1:0] valid_q, valid_d;
  logic [1:0]  phase_q [Channels];
  logic [15:0] lcid_q [Channels];
  logic [15:0] rcid_q [Channels];
  logic [15:0] psm_q [Channels];

  logic            busy_q;
  logic [CntW-1:0] ptr_q;
  logic [1:0]      kind_q;
  logic            hit_q;
  logic [IdxW-1:0] hidx_q;
  logic [15:0]     key;
  logic            match;
  result_t         res_q, second_q;
  logic            two_q;

  assign key = (item_q.op == OP_RX && item_q.cid == CID_SIG) ? item_q.word0 :
               (item_q.op == OP_RX) ? item_q.cid : item_q.psm;

  always_comb begin
    logic [IdxW-1:0] p;
    p = ptr_q[IdxW-1:0];
    unique case (kind_q)
      SRCH_LCID: match = valid_q[p] && lcid_q[p] == key;
      SRCH_PSM:  match = valid_q[p] && psm_q[p] == key;
      default:   match = !valid_q[p];
    endcase
  end

  // one entry per cycle, stops at first hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ptr_q  <= '0;
      kind_q <= SRCH_LCID;
      hit_q  <= 1'b0;
      hidx_q <= '0;
    end else if (cmd_i.scan_start) begin
      busy_q <= 1'b1;
      ptr_q  <= '0;
      kind_q <= cmd_i.scan_kind;
      hit_q  <= 1'b0;
    end else if (busy_q) begin
      if (match) begin
        hit_q  <= 1'b1;
        hidx_q <= ptr_q[IdxW-1:0];
        busy_q <= 1'b0;
      end else if (ptr_q == CntW'(Channels - 1)) begin
        busy_q <= 1'b0;
      end
      ptr_q <= ptr_q + 1'b1;
    end
  end

  assign stat_o.scan_busy = busy_q;
  assign stat_o.two_results = two_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
  end

  // result forming
  result_t r0, r1;
  logic    two;
  logic    wr_en;
  logic [1:0] wr_phase;
  logic    alloc, freeit;

  always_comb begin
    logic [1:0]  ph;
    logic [15:0] rc, lc, ps;
    ph = phase_q[hidx_q];
    rc = rcid_q[hidx_q];
    lc = lcid_q[hidx_q];
    ps = psm_q[hidx_q];
    r0 = '0;
    r1 = '0;
    r0.last = 1'b1;
    r1.last = 1'b1;
    r0.kind = KIND_NONE;
    two = 1'b0;
    wr_en = 1'b0;
    wr_phase = PH_WCFG;
    alloc = 1'b0;
    freeit = 1'b0;
    priority if (item_q.op == OP_RX) begin
      priority if (item_q.continuation) begin
        r0.kind = KIND_ERR; r0.error = ERR_CONT;
      end else if (item_q.buf_len < 16'd4) begin
        r0.kind = KIND_ERR; r0.error = ERR_SIZE;
      end else if (item_q.cid == CID_SIG) begin
        priority if (item_q.frame_len < 16'd4) begin
          r0.kind = KIND_ERR; r0.error = ERR_SIZE;
        end else if (item_q.cmd_code == CMD_INFO_REQ) begin
          r0.kind = KIND_SIG; r0.code = CMD_INFO_RSP; r0.ident = item_q.cmd_id;
          r0.out_cid = CID_SIG; r0.out_len = 16'd4;
          r0.param0 = item_q.word0; r0.param1 = 16'd1;
        end else if (item_q.cmd_code == CMD_CONN_REQ) begin
          if (!hit_q) begin
            r0.kind = KIND_ERR; r0.error = ERR_FULL;
          end else begin
            alloc = 1'b1;
            r0.kind = KIND_SIG; r0.code = CMD_CONN_RSP; r0.ident = item_q.cmd_id;
            r0.out_cid = CID_SIG; r0.out_len = 16'd8;
            r0.param0 = item_q.word1 + LcidOffset; r0.param1 = item_q.word1;
          end
        end else if (!hit_q) begin
          r0.kind = KIND_ERR; r0.error = ERR_NOCH;
        end else if (ph == PH_WCFG) begin
          if (item_q.cmd_code == CMD_CFG_REQ) begin
            two = 1'b1;
            wr_en = 1'b1; wr_phase = PH_WRSP;
            r0.kind = KIND_SIG; r0.code = CMD_CFG_RSP; r0.ident = item_q.cmd_id;
            r0.out_cid = CID_SIG; r0.out_len = 16'd6; r0.param0 = rc;
            r0.last = 1'b0;
            r1.kind = KIND_SIG; r1.code = CMD_CFG_REQ; r1.ident = item_q.cmd_id;
            r1.out_cid = CID_SIG; r1.out_len = 16'd8; r1.param0 = rc;
            r1.param2 = OPT_MTU_HDR; r1.param3 = mtu_i;
          end
        end else if (ph == PH_WRSP && item_q.cmd_code == CMD_CFG_RSP) begin
          if (item_q.word1 != 16'd0 || item_q.word2 != 16'd0) begin
            r0.kind = KIND_ERR; r0.error = ERR_NOTOPEN;
          end else begin
            wr_en = 1'b1; wr_phase = PH_OPEN;
          end
        end else if ((ph == PH_WRSP || ph == PH_OPEN) &&
                     item_q.cmd_code == CMD_DISC_REQ) begin
          freeit = 1'b1;
          r0.kind = KIND_SIG; r0.code = CMD_DISC_RSP; r0.ident = item_q.cmd_id;
          r0.out_cid = CID_SIG; r0.out_len = 16'd4; r0.param0 = lc; r0.param1 = rc;
        end else begin
          r0.kind = KIND_NONE;
        end
      end else if (item_q.cid < CID_DYN) begin
        r0.kind = KIND_ERR; r0.error = ERR_CID;
      end else if (!hit_q) begin
        r0.kind = KIND_ERR; r0.error = ERR_NOCH;
      end else if (ph != PH_OPEN) begin
        r0.kind = KIND_ERR; r0.error = ERR_NOTOPEN;
      end else if (ps == PSM_SDP || ps == PSM_RFCOMM) begin
        r0.kind = (ps == PSM_SDP) ? KIND_SDP : KIND_RFCOMM;
        r0.out_cid = item_q.cid; r0.out_len = item_q.frame_len;
      end else begin
        r0.kind = KIND_NONE;
      end
    end else if (item_q.op == OP_SEND || item_q.op == OP_DISC) begin
      if (!hit_q) begin
        r0.kind = KIND_ERR; r0.error = ERR_NOCH;
      end else if (item_q.op == OP_SEND) begin
        r0.kind = KIND_DATA; r0.out_cid = rc; r0.out_len = item_q.frame_len;
      end else begin
        r0.kind = KIND_SIG; r0.code = CMD_DISC_REQ; r0.ident = 8'h01;
        r0.out_cid = CID_SIG; r0.out_len = 16'd4; r0.param0 = rc; r0.param1 = lc;
      end
    end else begin
      r0.kind = KIND_NONE;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.decide && alloc) valid_d[hidx_q] = 1'b1;
    if (cmd_i.decide && freeit) valid_d[hidx_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      two_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.decide) two_q <= two;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_q    <= r0;
      second_q <= r1;
      if (alloc) begin
        psm_q[hidx_q]   <= item_q.word0;
        rcid_q[hidx_q]  <= item_q.word1;
        lcid_q[hidx_q]  <= item_q.word1 + LcidOffset;
        phase_q[hidx_q] <= PH_WCFG;
      end
      if (wr_en) phase_q[hidx_q] <= wr_phase;
    end else if (cmd_i.emit2) begin
      res_q <= second_q;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/core/l2cap_ctrl.sv */
// controller: sequences capture, table scan, decision and result handoff
// depends on l2cap_pkg
module l2cap_ctrl import l2cap_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t item_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_OUT1 = 3'd4;
  localparam logic [2:0] S_OUT2 = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] skind_q, skind_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT1) || (state_q == S_OUT2);

  always_comb begin
    state_d = state_q;
    skind_d = skind_q;
    cmd_o = '0;
    cmd_o.scan_kind = skind_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (item_i.op == OP_RX && item_i.cid == CID_SIG &&
              item_i.cmd_code == CMD_CONN_REQ) skind_d = SRCH_FREE;
          else if (item_i.op == OP_RX) skind_d = SRCH_LCID;
          else skind_d = SRCH_PSM;
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.scan_start = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: if (!stat_i.scan_busy) state_d = S_DECIDE;
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = S_OUT1;
      end
      S_OUT1: begin
        if (out_ready_i) begin
          if (stat_i.two_results) begin
            cmd_o.emit2 = 1'b1;
            state_d = S_OUT2;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_OUT2: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      skind_q <= SRCH_LCID;
    end else begin
      state_q <= state_d;
      skind_q <= skind_d;
    end
  end

endmodule

/* rtl/core/l2cap_signalling_channel_engine_top.sv */
// l2cap signalling engine: one item at a time; the first result is valid once the input word
// is taken and has passed capture, scan start, the scan of the table entries up to the first
// hit or the last entry, and decide; a second result follows in the cycle after the first is taken
// reset clears the channel valid bits and sets mtu to 672; entry data is
// written on allocation and needs no reset
module l2cap_signalling_channel_engine_top import l2cap_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op, buf_len, continuation, frame_len, cid, cmd_code, cmd_id, word0..2, psm (zero fill)
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // code, ident, out_cid, out_len, param0..param3, error (zero fill)
  output logic [119:0] m_axis_tdata,
  // kind
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  logic [15:0] mtu_q;
  item_t   item;
  result_t res;
  cmd_t    cmd;
  stat_t   stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mtu_q <= MtuReset;
    else if (cfg_we_i) mtu_q <= cfg_wdata_i;
  end

  assign item.op           = s_axis_tdata[1:0];
  assign item.buf_len      = s_axis_tdata[17:2];
  assign item.continuation = s_axis_tdata[18];
  assign item.frame_len    = s_axis_tdata[34:19];
  assign item.cid          = s_axis_tdata[50:35];
  assign item.cmd_code     = s_axis_tdata[58:51];
  assign item.cmd_id       = s_axis_tdata[66:59];
  assign item.word0        = s_axis_tdata[82:67];
  assign item.word1        = s_axis_tdata[98:83];
  assign item.word2        = s_axis_tdata[114:99];
  assign item.psm          = s_axis_tdata[130:115];

  l2cap_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .item_i(item),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i(stat),
    .cmd_o(cmd)
  );

  l2cap_datapath u_dp (
    .clk_i, .rst_ni,
    .item_i(item),
    .mtu_i(mtu_q),
    .cmd_i(cmd),
    .stat_o(stat),
    .res_o(res)
  );

  assign m_axis_tdata = {5'b0, res.error, res.param3, res.param2, res.param1, res.param0,
                         res.out_len, res.out_cid, res.ident, res.code};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
  a_no_dual_hs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken while result pending");
  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("second result missing");
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_ERR) |-> m_axis_tlast)
    else $error("error result not final");
`endif

endmodule
